/* rtl/core/assert_macros.svh */
// Assertion macros for the RTL of the core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising edge of clk, off while arst_n is low.
`define EVFD_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("evfd assertion failed");

// Concurrent check that an expression never holds.
`define EVFD_ASSERT_NEVER(lbl, expr) `EVFD_ASSERT(lbl, !(expr))

`endif

/* rtl/core/evfd_pkg.sv */
// Types, constants and helper functions of the event freshness and duplicate filter.
package evfd_pkg;

	// Seen store geometry. The depth is a power of two, so the slot is the low hash bits.
	localparam int unsigned StoreDepth = 4096;
	localparam int unsigned SlotW      = $clog2(StoreDepth);

	// Field widths.
	localparam int unsigned HashW     = 64;
	localparam int unsigned ByteW     = 8;
	localparam int unsigned MsW       = 48;
	localparam int unsigned NowW      = 38;
	localparam int unsigned SkewW     = 16;
	localparam int unsigned CountW    = 32;
	localparam int unsigned CfgIndexW = 8;

	// Time in seconds with one bit of headroom, and that time scaled to milliseconds.
	localparam int unsigned TimeW = NowW + 1;
	localparam int unsigned ProdW = TimeW + 10;

	// FNV-1a 64-bit offset basis.
	localparam logic [HashW-1:0] FnvBasis = 64'hCBF29CE484222325;

	// Register reset values.
	localparam logic [SkewW-1:0] SkewForwardReset = 16'd20;
	localparam logic [SkewW-1:0] SkewBackReset    = 16'd900;

	// Configuration register indexes.
	localparam logic [CfgIndexW-1:0] CFG_SKEW_FORWARD = 8'd0;
	localparam logic [CfgIndexW-1:0] CFG_SKEW_BACK    = 8'd1;

	// Verdict codes.
	typedef enum logic [1:0] {
		VERDICT_VALID  = 2'd0,
		VERDICT_FUTURE = 2'd1,
		VERDICT_OLD    = 2'd2,
		VERDICT_DUP    = 2'd3
	} verdict_t;

	// One FNV-1a round. The prime is 2^40 + 0x1B3, so the product is a sum of shifts.
	function automatic logic [HashW-1:0] fnv_step(logic [HashW-1:0] acc, logic [ByteW-1:0] b);
		logic [HashW-1:0] x;
		x = acc ^ {{(HashW-ByteW){1'b0}}, b};
		return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
	endfunction

	// Seconds to milliseconds: s * 1000 = s * 1024 - s * 16 - s * 8.
	function automatic logic [ProdW-1:0] sec_to_ms(logic [TimeW-1:0] s);
		logic [ProdW-1:0] w;
		w = {{(ProdW-TimeW){1'b0}}, s};
		return (w << 10) - (w << 4) - (w << 3);
	endfunction

endpackage

/* rtl/core/evfd_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
module evfd_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port; the data word holds while no read is requested.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* rtl/core/event_freshness_and_duplicate_filter.sv */
// Top level of the event freshness and duplicate filter.
//
// The id of an event streams in one byte per word and is folded into a 64-bit
// FNV-1a hash; the word that carries the last byte also carries the event time
// in milliseconds and the current time in seconds, and only that word yields a
// result word. The block takes one input word per clock cycle unless clearing or
// a stalled result channel holds it back: the rate is set by the hash accumulator,
// whose loop holds a single register, and by the seen store, whose single read and
// single write port each serve one event per cycle. A result passes the input
// register, then stage 2 with the store read, then the result register. After
// reset the block clears all 4096 entries of the seen store, one entry a cycle,
// holding in_ready low meanwhile; configuration writes are taken at any time.
`include "assert_macros.svh"

module event_freshness_and_duplicate_filter (
	input  logic                            clk,
	input  logic                            arst_n,
	// Configuration write channel.
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [evfd_pkg::CfgIndexW-1:0]  cfg_index,
	input  logic [evfd_pkg::SkewW-1:0]      cfg_data,
	// Input channel.
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [evfd_pkg::ByteW-1:0]      id_byte,
	input  logic                            id_last,
	input  logic [evfd_pkg::MsW-1:0]        event_ms,
	input  logic [evfd_pkg::NowW-1:0]       now_sec,
	// Result channel.
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [1:0]                      verdict,
	output logic [evfd_pkg::HashW-1:0]      fingerprint,
	output logic [evfd_pkg::CountW-1:0]     seen_total,
	output logic [evfd_pkg::CountW-1:0]     valid_total,
	output logic [evfd_pkg::CountW-1:0]     invalid_total
);

	import evfd_pkg::*;

	// Configuration registers.
	logic [SkewW-1:0] skew_fwd_q;
	logic [SkewW-1:0] skew_back_q;

	// Store clearing after reset.
	logic             clr_busy_q;
	logic [SlotW-1:0] clr_addr_q;

	// Hash and counters.
	logic [HashW-1:0]  hash_acc_q;
	logic [CountW-1:0] seen_q;
	logic [CountW-1:0] valid_cnt_q;
	logic [CountW-1:0] invalid_cnt_q;

	// Stage 1: input register.
	logic             vld_s1;
	logic [ByteW-1:0] byte_s1;
	logic             last_s1;
	logic [MsW-1:0]   ms_s1;
	logic [NowW-1:0]  now_s1;

	// Stage 2: hash and time checks, waiting on the store read.
	logic             vld_s2;
	logic [HashW-1:0] hash_s2;
	logic             future_s2;
	logic             old_s2;

	// Stage 3: result register.
	logic              vld_s3;
	verdict_t          verdict_s3;
	logic [HashW-1:0]  fp_s3;
	logic [CountW-1:0] seen_s3;
	logic [CountW-1:0] valid_cnt_s3;
	logic [CountW-1:0] invalid_cnt_s3;

	// Same-cycle write bypass for the store read.
	logic             byp_hit_q;
	logic [HashW-1:0] byp_data_q;

	// Flow control and datapath wires.
	logic             s3_free;
	logic             s2_adv;
	logic             s2_free;
	logic             s1_adv;
	logic             in_fire;
	logic [HashW-1:0] hash_new;
	logic [ProdW-1:0] fwd_lim;
	logic [ProdW-1:0] old_lim;
	logic [NowW-1:0]  now_minus_back;
	logic             now_gt_back;
	logic             future_new;
	logic             old_new;
	logic             ram_we;
	logic [SlotW-1:0] ram_waddr;
	logic [HashW-1:0] ram_wdata;
	logic             ram_re;
	logic [HashW-1:0] ram_rdata;
	logic [HashW-1:0] stored_hash;
	logic             pass_s2;
	verdict_t         verdict_new;
	logic [CountW-1:0] seen_nxt;
	logic [CountW-1:0] valid_cnt_nxt;
	logic [CountW-1:0] invalid_cnt_nxt;

	// Handshakes: each stage moves on when the one after it has room; stage 1 passes non-last words on without waiting.
	assign s3_free   = !vld_s3 || out_ready;
	assign s2_adv    = vld_s2 && s3_free;
	assign s2_free   = !vld_s2 || s3_free;
	assign s1_adv    = vld_s1 && (!last_s1 || s2_free);
	assign in_ready  = !clr_busy_q && (!vld_s1 || s1_adv);
	assign in_fire   = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	// Configuration writes; unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skew_fwd_q  <= SkewForwardReset;
			skew_back_q <= SkewBackReset;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_SKEW_FORWARD: skew_fwd_q  <= cfg_data;
				CFG_SKEW_BACK:    skew_back_q <= cfg_data;
				default:          ;
			endcase
		end
	end

	// Clearing pass over the seen store after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + SlotW'(1);
			if (clr_addr_q == SlotW'(StoreDepth - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// Stage 1 control and payload.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_fire) begin
			vld_s1 <= 1'b1;
		end else if (s1_adv) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			byte_s1 <= id_byte;
			last_s1 <= id_last;
			ms_s1   <= event_ms;
			now_s1  <= now_sec;
		end
	end

	// Hash round on the byte in stage 1.
	assign hash_new = fnv_step(hash_acc_q, byte_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_acc_q <= FnvBasis;
		end else if (s1_adv) begin
			hash_acc_q <= last_s1 ? FnvBasis : hash_new;
		end
	end

	// Freshness checks in milliseconds, so the event time needs no division.
	// Too far ahead when event_ms >= 1000 * (now + forward skew + 1).
	// Too old when now > back skew and event_ms < 1000 * (now - back skew).
	assign fwd_lim        = sec_to_ms(TimeW'(now_s1) + TimeW'(skew_fwd_q) + TimeW'(1));
	assign now_gt_back    = now_s1 > NowW'(skew_back_q);
	assign now_minus_back = now_s1 - NowW'(skew_back_q);
	assign old_lim        = sec_to_ms(TimeW'(now_minus_back));
	assign future_new     = ProdW'(ms_s1) >= fwd_lim;
	assign old_new        = now_gt_back && (ProdW'(ms_s1) < old_lim);

	// Stage 2 control and payload.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (s1_adv && last_s1) begin
			vld_s2 <= 1'b1;
		end else if (s2_adv) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && last_s1) begin
			hash_s2   <= hash_new;
			future_s2 <= future_new;
			old_s2    <= old_new;
		end
	end

	// Store access: read when an event enters stage 2, write when a fresh one leaves it or while clearing.
	assign pass_s2   = !future_s2 && !old_s2;
	assign ram_re    = s1_adv && last_s1;
	assign ram_we    = clr_busy_q || (s2_adv && pass_s2);
	assign ram_waddr = clr_busy_q ? clr_addr_q : hash_s2[SlotW-1:0];
	assign ram_wdata = clr_busy_q ? '0 : hash_s2;

	evfd_ram #(
		.WIDTH (HashW),
		.DEPTH (StoreDepth)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (hash_new[SlotW-1:0]),
		.rdata (ram_rdata)
	);

	// A write in the same cycle as the read to the same slot is not seen by the read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_hit_q <= 1'b0;
		end else if (ram_re) begin
			byp_hit_q <= ram_we && (ram_waddr == hash_new[SlotW-1:0]);
		end
	end

	always_ff @(posedge clk) begin
		if (ram_re) begin
			byp_data_q <= ram_wdata;
		end
	end

	assign stored_hash = byp_hit_q ? byp_data_q : ram_rdata;

	// Verdict: future first, then old, then the duplicate lookup.
	always_comb begin
		if (future_s2) begin
			verdict_new = VERDICT_FUTURE;
		end else if (old_s2) begin
			verdict_new = VERDICT_OLD;
		end else if (stored_hash == hash_s2) begin
			verdict_new = VERDICT_DUP;
		end else begin
			verdict_new = VERDICT_VALID;
		end
	end

	// Running counts including the event in stage 2.
	assign seen_nxt        = seen_q + CountW'(1);
	assign valid_cnt_nxt   = (verdict_new == VERDICT_VALID) ? valid_cnt_q + CountW'(1)
	                                                        : valid_cnt_q;
	assign invalid_cnt_nxt = (verdict_new == VERDICT_VALID) ? invalid_cnt_q
	                                                        : invalid_cnt_q + CountW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q        <= '0;
			valid_cnt_q   <= '0;
			invalid_cnt_q <= '0;
		end else if (s2_adv) begin
			seen_q        <= seen_nxt;
			valid_cnt_q   <= valid_cnt_nxt;
			invalid_cnt_q <= invalid_cnt_nxt;
		end
	end

	// Stage 3: result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (s2_adv) begin
			vld_s3 <= 1'b1;
		end else if (out_ready) begin
			vld_s3 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_adv) begin
			verdict_s3     <= verdict_new;
			fp_s3          <= hash_s2;
			seen_s3        <= seen_nxt;
			valid_cnt_s3   <= valid_cnt_nxt;
			invalid_cnt_s3 <= invalid_cnt_nxt;
		end
	end

	assign out_valid     = vld_s3;
	assign verdict       = verdict_s3;
	assign fingerprint   = fp_s3;
	assign seen_total    = seen_s3;
	assign valid_total   = valid_cnt_s3;
	assign invalid_total = invalid_cnt_s3;

	// Checks on the design's own bookkeeping.
	`EVFD_ASSERT_NEVER(a_no_accept_while_clearing, clr_busy_q && in_ready)
	`EVFD_ASSERT(a_counts_balance, seen_q == valid_cnt_q + invalid_cnt_q)
	`EVFD_ASSERT(a_hash_restarts, (s1_adv && last_s1) |=> (hash_acc_q == FnvBasis))
	`EVFD_ASSERT(a_clear_covers_store, $fell(clr_busy_q) |-> (clr_addr_q == '0))

endmodule

/* test/event_freshness_and_duplicate_filter_tb.sv */
// Self-checking testbench for the event freshness and duplicate filter, with its own predictor.
`timescale 1ns / 100ps

module event_freshness_and_duplicate_filter_tb;
	import evfd_pkg::*;

	localparam logic [HashW-1:0] FnvPrime = 64'd1099511628211;
	localparam logic [63:0] MsMask = 64'h0000_FFFF_FFFF_FFFF;
	localparam logic [NowW-1:0] NowMax = 38'h3F_FFFF_FFFF;
	localparam longint SecMax = 64'd281474976710;
	localparam logic [CfgIndexW-1:0] CfgUnmapped = 8'd2;
	localparam logic [CfgIndexW-1:0] CfgTopIndex = 8'hFF;
	localparam int IdMax = 24;
	localparam int PoolSize = 256;
	localparam int PhaseWords = 240;
	localparam int SettleCycles = 8;
	localparam int IdleLimit = 20000;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [CfgIndexW-1:0] cfg_index;
	logic [SkewW-1:0] cfg_data;
	logic in_valid;
	logic in_ready;
	logic [ByteW-1:0] id_byte;
	logic id_last;
	logic [MsW-1:0] event_ms;
	logic [NowW-1:0] now_sec;
	logic out_valid;
	logic out_ready;
	logic [1:0] verdict;
	logic [HashW-1:0] fingerprint;
	logic [CountW-1:0] seen_total;
	logic [CountW-1:0] valid_total;
	logic [CountW-1:0] invalid_total;

	event_freshness_and_duplicate_filter dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.id_byte(id_byte),
		.id_last(id_last),
		.event_ms(event_ms),
		.now_sec(now_sec),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.verdict(verdict),
		.fingerprint(fingerprint),
		.seen_total(seen_total),
		.valid_total(valid_total),
		.invalid_total(invalid_total)
	);

	// One judged event as the block should report it.
	typedef struct {
		verdict_t verdict;
		logic [HashW-1:0] fingerprint;
		logic [CountW-1:0] seen;
		logic [CountW-1:0] valid;
		logic [CountW-1:0] invalid;
	} judgement_t;

	// Predictor state: skews, running hash, seen store and counters.
	logic [SkewW-1:0] skew_fwd;
	logic [SkewW-1:0] skew_back;
	logic [HashW-1:0] running_hash;
	logic [HashW-1:0] seen_hashes [StoreDepth];
	logic [CountW-1:0] seen_count;
	logic [CountW-1:0] valid_count;
	logic [CountW-1:0] invalid_count;
	judgement_t awaited_judgements [$];

	// Id being sent, and a pool of ids sent earlier for duplicates.
	logic [ByteW-1:0] cur_id [IdMax];
	logic [ByteW-1:0] id_pool [PoolSize][IdMax];
	int id_len [PoolSize];
	int pool_count;

	int words_sent;
	int burst_left;
	int mismatches;
	int idle_cycles;
	int stall_left;
	int stall_pct;

	always #5 clk = ~clk;

	// Fold one word into the predicted hash and judge the event on its last byte.
	task automatic judge_word(input logic [ByteW-1:0] b, input logic l,
		input logic [MsW-1:0] ms, input logic [NowW-1:0] ns);
		logic [HashW-1:0] h;
		logic [63:0] ev_sec;
		logic [SlotW-1:0] slot;
		judgement_t j;
		h = (running_hash ^ {{(HashW-ByteW){1'b0}}, b}) * FnvPrime;
		if (!l) begin
			running_hash = h;
		end else begin
			running_hash = FnvBasis;
			ev_sec = {16'd0, ms} / 64'd1000;
			if (ev_sec > {26'd0, ns} + {48'd0, skew_fwd}) begin
				j.verdict = VERDICT_FUTURE;
			end else if (ev_sec + {48'd0, skew_back} < {26'd0, ns}) begin
				j.verdict = VERDICT_OLD;
			end else begin
				slot = h[SlotW-1:0];
				j.verdict = (seen_hashes[slot] == h) ? VERDICT_DUP : VERDICT_VALID;
				seen_hashes[slot] = h;
			end
			seen_count = seen_count + 1;
			if (j.verdict == VERDICT_VALID)
				valid_count = valid_count + 1;
			else
				invalid_count = invalid_count + 1;
			j.fingerprint = h;
			j.seen = seen_count;
			j.valid = valid_count;
			j.invalid = invalid_count;
			awaited_judgements.push_back(j);
		end
	endtask

	// Send one input word; the sender runs in bursts with random gaps between them.
	task automatic send_word(input logic [ByteW-1:0] b, input logic l,
		input logic [MsW-1:0] ms, input logic [NowW-1:0] ns);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, 30);
		end
		in_valid <= 1'b1;
		id_byte <= b;
		id_last <= l;
		event_ms <= ms;
		now_sec <= ns;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		judge_word(b, l, ms, ns);
		words_sent++;
		burst_left--;
		@(negedge clk);
	endtask

	// Send the id held in cur_id; only its last word carries meaningful times.
	task automatic send_event(input int len, input logic [MsW-1:0] ms,
		input logic [NowW-1:0] ns);
		for (int i = 0; i < len; i++) begin
			if (i == len - 1)
				send_word(cur_id[i], 1'b1, ms, ns);
			else
				send_word(cur_id[i], 1'b0, MsW'({$urandom, $urandom}),
					NowW'({$urandom, $urandom}));
		end
	endtask

	task automatic send_one(input logic [ByteW-1:0] b, input logic [MsW-1:0] ms,
		input logic [NowW-1:0] ns);
		cur_id[0] = b;
		send_event(1, ms, ns);
	endtask

	// Write one register and mirror it in the predictor.
	task automatic write_register(input logic [CfgIndexW-1:0] idx, input logic [SkewW-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (idx == CFG_SKEW_FORWARD)
			skew_fwd = val;
		else if (idx == CFG_SKEW_BACK)
			skew_back = val;
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// Hold the sender until every awaited judgement has come and the pipeline is empty.
	task automatic drain_results();
		in_valid <= 1'b0;
		while (awaited_judgements.size() != 0) @(negedge clk);
		repeat (SettleCycles) @(negedge clk);
		burst_left = 0;
	endtask

	// Time window edges and duplicates with the skews left at their reset values.
	task automatic test_reset_window();
		send_one(8'h00, 48'd0, 38'd0);
		send_one(8'hFF, MsW'(MsMask), NowMax);
		send_one(8'h00, 48'd0, 38'd0);
		cur_id[0] = 8'h41;
		cur_id[1] = 8'h42;
		send_event(2, 48'd1020999, 38'd1000);
		send_one(8'h43, 48'd1021000, 38'd1000);
		send_one(8'h44, 48'd100000, 38'd1000);
		send_one(8'h45, 48'd99999, 38'd1000);
		// An event rejected by time leaves the store alone, so its fresh resend is valid.
		send_one(8'h46, 48'd0, 38'd1000);
		send_one(8'h46, 48'd1000000, 38'd1000);
		cur_id[0] = 8'h41;
		cur_id[1] = 8'h42;
		send_event(2, 48'd1000000, 38'd1000);
		send_one(8'h47, MsW'((64'(NowMax) - 64'd900) * 64'd1000), NowMax);
	endtask

	// Both skews at zero and at their maximum, then writes to unmapped indexes.
	task automatic test_skew_extremes();
		drain_results();
		write_register(CFG_SKEW_FORWARD, 16'd0);
		write_register(CFG_SKEW_BACK, 16'd0);
		send_one(8'h50, 48'd5000999, 38'd5000);
		send_one(8'h51, 48'd5001000, 38'd5000);
		send_one(8'h52, 48'd4999999, 38'd5000);
		drain_results();
		write_register(CFG_SKEW_FORWARD, 16'hFFFF);
		write_register(CFG_SKEW_BACK, 16'hFFFF);
		send_one(8'h53, 48'd165535000, 38'd100000);
		send_one(8'h54, 48'd165536000, 38'd100000);
		send_one(8'h55, 48'd34465000, 38'd100000);
		send_one(8'h56, 48'd34464999, 38'd100000);
		drain_results();
		write_register(CfgUnmapped, 16'd0);
		write_register(CfgTopIndex, 16'd0);
		send_one(8'h57, 48'd165535000, 38'd100000);
	endtask

	// One random event: mostly times near the window edges, some pure noise.
	task automatic random_event();
		int len;
		int pick;
		longint delta;
		longint ev_sec;
		logic [63:0] ms;
		logic [NowW-1:0] ns;
		if (pool_count > 0 && $urandom_range(0, 99) < 30) begin
			pick = $urandom_range(0, pool_count - 1);
			len = id_len[pick];
			for (int i = 0; i < len; i++)
				cur_id[i] = id_pool[pick][i];
		end else begin
			len = ($urandom_range(0, 4) == 0) ? $urandom_range(7, IdMax) : $urandom_range(1, 6);
			if (pool_count < PoolSize) begin
				pick = pool_count;
				pool_count++;
			end else begin
				pick = $urandom_range(0, PoolSize - 1);
			end
			id_len[pick] = len;
			for (int i = 0; i < len; i++) begin
				cur_id[i] = ByteW'($urandom);
				id_pool[pick][i] = cur_id[i];
			end
		end
		if ($urandom_range(0, 99) < 15) begin
			ms = {$urandom, $urandom} & MsMask;
			ns = NowW'({$urandom, $urandom});
		end else begin
			case ($urandom_range(0, 3))
				0: ns = NowW'($urandom_range(0, 3000));
				1: ns = NowMax - NowW'($urandom_range(0, 3000));
				default: ns = NowW'({$urandom, $urandom});
			endcase
			case ($urandom_range(0, 5))
				0: delta = longint'(skew_fwd);
				1: delta = longint'(skew_fwd) + 1;
				2: delta = -longint'(skew_back);
				3: delta = -longint'(skew_back) - 1;
				default: delta = longint'($urandom_range(0, skew_fwd + skew_back + 10))
					- longint'(skew_back) - 5;
			endcase
			ev_sec = longint'({26'd0, ns}) + delta;
			if (ev_sec < 0)
				ev_sec = 0;
			if (ev_sec > SecMax)
				ev_sec = SecMax;
			ms = 64'(ev_sec) * 64'd1000 + 64'($urandom_range(0, 999));
			if (ms > MsMask)
				ms = MsMask;
		end
		send_event(len, ms[MsW-1:0], ns);
	endtask

	// Random traffic over several skew settings, draining between them.
	task automatic test_random_traffic();
		int target;
		logic [SkewW-1:0] f;
		logic [SkewW-1:0] k;
		for (int p = 0; p < 6; p++) begin
			drain_results();
			case (p)
				0: begin
					f = SkewW'($urandom);
					k = SkewW'($urandom);
				end
				1: begin
					f = 16'd0;
					k = 16'd0;
				end
				2: begin
					f = 16'hFFFF;
					k = 16'hFFFF;
				end
				3: begin
					f = SkewForwardReset;
					k = SkewBackReset;
				end
				4: begin
					f = SkewW'($urandom_range(0, 30));
					k = SkewW'($urandom_range(0, 30));
				end
				default: begin
					f = 16'hFFFF;
					k = 16'd0;
				end
			endcase
			write_register(CFG_SKEW_FORWARD, f);
			write_register(CFG_SKEW_BACK, k);
			target = words_sent + PhaseWords;
			while (words_sent < target) random_event();
		end
	endtask

	task automatic compare_field(input string name, input logic [63:0] want_v,
		input logic [63:0] got_v);
		if (want_v !== got_v) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch in %s: expected %h, got %h", name, want_v, got_v);
		end
	endtask

	// Check each accepted result word against the oldest awaited judgement.
	always @(posedge clk) begin
		judgement_t want;
		if (arst_n && out_valid && out_ready) begin
			if (awaited_judgements.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result word, fingerprint %h", fingerprint);
			end else begin
				want = awaited_judgements.pop_front();
				compare_field("verdict", 64'(want.verdict), 64'(verdict));
				compare_field("fingerprint", want.fingerprint, fingerprint);
				compare_field("seen_total", 64'(want.seen), 64'(seen_total));
				compare_field("valid_total", 64'(want.valid), 64'(valid_total));
				compare_field("invalid_total", 64'(want.invalid), 64'(invalid_total));
			end
		end
	end

	// Receiver stalls with a rate that changes at random intervals.
	always @(negedge clk) begin
		if (stall_left == 0) begin
			case ($urandom_range(0, 3))
				0: stall_pct = 0;
				1: stall_pct = 10;
				2: stall_pct = 50;
				default: stall_pct = 85;
			endcase
			stall_left = $urandom_range(16, 128);
		end
		stall_left--;
		out_ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	// Watchdog on cycles with no word accepted on any channel.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IdleLimit) begin
				$display("** event_freshness_and_duplicate_filter: FAILED **");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		id_byte = '0;
		id_last = 1'b0;
		event_ms = '0;
		now_sec = '0;
		out_ready = 1'b0;
		stall_left = 0;
		stall_pct = 0;
		idle_cycles = 0;
		mismatches = 0;
		words_sent = 0;
		burst_left = 0;
		pool_count = 0;
		skew_fwd = SkewForwardReset;
		skew_back = SkewBackReset;
		running_hash = FnvBasis;
		seen_count = '0;
		valid_count = '0;
		invalid_count = '0;
		foreach (seen_hashes[i])
			seen_hashes[i] = '0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_reset_window();
		test_skew_extremes();
		test_random_traffic();
		drain_results();

		if (mismatches == 0)
			$display("** event_freshness_and_duplicate_filter: PASSED **");
		else
			$display("** event_freshness_and_duplicate_filter: FAILED **");
		$finish;
	end

endmodule
